// File: rtl/twa_pkg.sv
`default_nettype none

package twa_pkg;

  localparam int unsigned SAMPLE_W = 16;

  // Divide by ten as multiply by ceil(2^23 / 10) and shift by 23.
  // Exact for magnitudes below 2^22.
  localparam int unsigned RECIP_M     = 838861;
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned RECIP_SHIFT = 23;

  localparam int unsigned POS_LIMIT = 32767;
  localparam int unsigned NEG_LIMIT = 32768;

  typedef struct packed {
    logic load;
    logic advance;
    logic emit;
  } twa_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/three_axis_window_average.sv
// Sliding-window averager for one three-axis sensor stream.
// Input channel: in_valid_i / in_stall_o with sample_x_i, sample_y_i,
// sample_z_i (signed 16 bit). A request is taken at a rising edge with
// in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with avg_x_o, avg_y_o, avg_z_o.
// Each request gives one result: per axis, the sum of the last WINDOW_LEN
// samples (the new one included) divided by ten, truncated toward zero,
// saturated to 16 bits.
// Three register stages: input, window sum, result. A request passes
// through them in that order.
// Throughput is one request per cycle while out_stall_i is low; the per-axis running sum
// needs one add and one subtract per request and the divide is one constant multiply.
// Each stage moves on when the next one is empty or moving, so a stalled
// result holds in the output register while two more requests are taken.
// Reset clears the windows to zero and empties all stages.
`default_nettype none

module three_axis_window_average #(
  parameter int WINDOW_LEN = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] sample_x_i,
  input  wire logic signed [15:0] sample_y_i,
  input  wire logic signed [15:0] sample_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      avg_x_o,
  output logic signed [15:0]      avg_y_o,
  output logic signed [15:0]      avg_z_o
);
  import twa_pkg::*;

  logic      s1_vld_q, s1_vld_d;
  logic      s2_vld_q, s2_vld_d;
  logic      out_vld_q, out_vld_d;
  logic      en2, en3;
  logic      accept, out_fire;
  twa_ctrl_t ctrl;

  assign en3      = !out_vld_q || !out_stall_i;
  assign en2      = !s2_vld_q || en3;
  assign in_stall_o = s1_vld_q && !en2;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_fire = out_vld_q && !out_stall_i;

  assign ctrl.load    = accept;
  assign ctrl.advance = s1_vld_q && en2;
  assign ctrl.emit    = s2_vld_q && en3;

  always_comb begin
    s1_vld_d  = accept ? 1'b1 : (ctrl.advance ? 1'b0 : s1_vld_q);
    s2_vld_d  = ctrl.advance ? 1'b1 : (ctrl.emit ? 1'b0 : s2_vld_q);
    out_vld_d = ctrl.emit ? 1'b1 : (out_fire ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

  twa_axis #(.WINDOW_LEN(WINDOW_LEN)) u_axis_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (sample_x_i),
    .avg_o    (avg_x_o)
  );

  twa_axis #(.WINDOW_LEN(WINDOW_LEN)) u_axis_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (sample_y_i),
    .avg_o    (avg_y_o)
  );

  twa_axis #(.WINDOW_LEN(WINDOW_LEN)) u_axis_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (sample_z_i),
    .avg_o    (avg_z_o)
  );

  a_take_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_vld_q)
    else $error("accepted request not held in input stage");

  a_drain_unblocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_vld_q || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s2_vld_q && out_vld_q && out_stall_i) |-> in_stall_o)
    else $error("input taken with all stages full");

  a_advance_fills_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.advance |=> s2_vld_q)
    else $error("sum stage lost a request");

endmodule

`default_nettype wire

// File: rtl/twa_axis.sv
`default_nettype none

module twa_axis #(
  parameter int WINDOW_LEN = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  twa_pkg::twa_ctrl_t          ctrl_i,
  input  wire logic signed [15:0]     sample_i,
  output logic signed [15:0]          avg_o
);
  import twa_pkg::*;

  localparam int HIST_LEN = WINDOW_LEN - 1;
  localparam int SUM_W    = SAMPLE_W + 1 + $clog2(WINDOW_LEN);
  localparam int ABS_W    = SUM_W - 1;
  localparam int PROD_W   = ABS_W + RECIP_W;
  localparam int QW       = PROD_W - RECIP_SHIFT;
  localparam int QX       = (QW > SAMPLE_W + 1) ? QW : SAMPLE_W + 1;

  logic signed [SAMPLE_W-1:0] samp_q;
  logic signed [SAMPLE_W-1:0] hist_q [HIST_LEN];
  logic signed [SUM_W-1:0]    run_q, run_d;
  logic signed [SUM_W-1:0]    win_sum;
  logic                       neg_q;
  logic        [ABS_W-1:0]    mag_q, mag_d;
  logic        [PROD_W-1:0]   prod;
  logic        [QX-1:0]       qx;
  logic        [SAMPLE_W-1:0] sat_mag;
  logic        [SAMPLE_W-1:0] avg_q, avg_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      samp_q <= sample_i;
    end
  end

  // Running sum of the history; the window is the history plus the new sample.
  assign win_sum = run_q + SUM_W'(samp_q);
  assign run_d   = win_sum - SUM_W'(hist_q[0]);
  assign mag_d   = win_sum[SUM_W-1] ? ABS_W'(-win_sum) : ABS_W'(win_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      for (int k = 0; k < HIST_LEN; k++) begin
        hist_q[k] <= '0;
      end
    end else if (ctrl_i.advance) begin
      run_q <= run_d;
      for (int k = 0; k < HIST_LEN - 1; k++) begin
        hist_q[k] <= hist_q[k+1];
      end
      hist_q[HIST_LEN-1] <= samp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      neg_q <= win_sum[SUM_W-1];
      mag_q <= mag_d;
    end
  end

  assign prod = PROD_W'(mag_q) * PROD_W'(RECIP_M);
  assign qx   = QX'(prod[PROD_W-1:RECIP_SHIFT]);

  always_comb begin
    if (neg_q) begin
      sat_mag = (qx > QX'(NEG_LIMIT)) ? SAMPLE_W'(NEG_LIMIT) : qx[SAMPLE_W-1:0];
      avg_d   = -sat_mag;
    end else begin
      sat_mag = (qx > QX'(POS_LIMIT)) ? SAMPLE_W'(POS_LIMIT) : qx[SAMPLE_W-1:0];
      avg_d   = sat_mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      avg_q <= avg_d;
    end
  end

  assign avg_o = $signed(avg_q);

endmodule

`default_nettype wire
